[rtl/core/bq_pkg.sv]
`default_nettype none
package bq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam logic [4:0] LIMIT_RST = 5'd16;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	localparam logic REG_QUEUE_LIMIT = 1'b0;

	typedef struct packed {
		logic        en;
		logic        joined;
		logic        rejected;
		logic        served;
		logic [47:0] len;
		logic [31:0] wait_ticks;
	} stat_upd_t;

endpackage
`default_nettype wire

[rtl/core/bq_store.sv]
`default_nettype none
module bq_store #(
	parameter int QUEUE_DEPTH = bq_pkg::QUEUE_DEPTH_DEF,
	parameter int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [31:0]   wr_arr,
	input  wire logic [3:0]    wr_svc,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [31:0]   rd_arr,
	output logic      [3:0]    rd_svc
);

	logic [35:0] mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_svc, wr_arr};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			{rd_svc, rd_arr} <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[rtl/core/bq_stats.sv]
`default_nettype none
module bq_stats (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bq_pkg::stat_upd_t upd,
	output logic [31:0]            total_joined,
	output logic [31:0]            total_served,
	output logic [31:0]            total_turned_away,
	output logic [47:0]            sum_queue_length,
	output logic [47:0]            sum_wait
);

	logic [31:0] joined_q;
	logic [31:0] served_q;
	logic [31:0] rejected_q;
	logic [47:0] len_sum_q;
	logic [47:0] wait_sum_q;
	logic [48:0] len_add;
	logic [48:0] wait_add;

	assign len_add  = {1'b0, len_sum_q} + {1'b0, upd.len};
	assign wait_add = {1'b0, wait_sum_q} + {17'd0, upd.wait_ticks};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joined_q   <= '0;
			served_q   <= '0;
			rejected_q <= '0;
			len_sum_q  <= '0;
			wait_sum_q <= '0;
		end else if (upd.en) begin
			if (upd.joined && joined_q != '1) begin
				joined_q <= joined_q + 32'd1;
			end
			if (upd.served && served_q != '1) begin
				served_q <= served_q + 32'd1;
			end
			if (upd.rejected && rejected_q != '1) begin
				rejected_q <= rejected_q + 32'd1;
			end
			len_sum_q  <= len_add[48] ? bq_pkg::MAX48 : len_add[47:0];
			wait_sum_q <= wait_add[48] ? bq_pkg::MAX48 : wait_add[47:0];
		end
	end

	assign total_joined      = joined_q;
	assign total_served      = served_q;
	assign total_turned_away = rejected_q;
	assign sum_queue_length  = len_sum_q;
	assign sum_wait          = wait_sum_q;

endmodule
`default_nettype wire

[rtl/core/bounded_queue_single_server_stats.sv]
// accepted words and the head entry read are registered, then so is the result word
// in_stall holds off a new word until its result is calculated; a result
// waiting on out_stall holds the next word in calculation, stalling the input
// reset: arst_n clears pointers, counters, countdown, totals and queue_limit (16)
// the entry store is not cleared; entries are only read after being written
`default_nettype none
module bounded_queue_single_server_stats #(
	parameter int QUEUE_DEPTH = bq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        arrival,
	input  wire logic [3:0]  service_ticks,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             joined,
	output logic             turned_away,
	output logic             began_service,
	output logic      [31:0] wait_of_begun,
	output logic      [4:0]  queue_length,
	output logic      [3:0]  busy_left,
	output logic      [31:0] total_joined,
	output logic      [31:0] total_served,
	output logic      [31:0] total_turned_away,
	output logic      [47:0] sum_queue_length,
	output logic      [47:0] sum_wait
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	logic          st_q;
	logic [4:0]    limit_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [3:0]    busy_q;
	logic [31:0]   tick_q;

	logic          arr_s1;
	logic [3:0]    svc_s1;

	logic          out_valid_q;
	logic          joined_q;
	logic          rejected_q;
	logic          began_q;
	logic [31:0]   wait_q;
	logic [4:0]    qlen_q;
	logic [3:0]    busy_left_q;

	logic          in_acc;
	logic          cfg_wr;
	logic          calc_go;
	logic          full;
	logic          join_c;
	logic          rej_c;
	logic [CW-1:0] cnt1;
	logic [CW-1:0] cnt2;
	logic          serve;
	logic          fwd;
	logic [31:0]   rd_arr;
	logic [3:0]    rd_svc;
	logic [31:0]   hd_arr;
	logic [3:0]    hd_svc;
	logic [31:0]   wait_c;
	logic [3:0]    busy_new;
	logic [3:0]    busy_dec;

	bq_pkg::stat_upd_t upd;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == bq_pkg::REG_QUEUE_LIMIT) ? {27'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= bq_pkg::LIMIT_RST;
		end else if (cfg_wr && paddr[2] == bq_pkg::REG_QUEUE_LIMIT) begin
			limit_q <= pwdata[4:0];
		end
	end

	// handshake
	assign in_stall = (st_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign calc_go  = (st_q == ST_CALC) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (calc_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			arr_s1 <= arrival;
			svc_s1 <= service_ticks;
		end
	end

	// tick update
	assign full   = (32'(count_q) >= 32'(limit_q)) || (count_q == FULL_CNT);
	assign join_c = arr_s1 && !full;
	assign rej_c  = arr_s1 && full;
	assign cnt1   = count_q + CW'(join_c);
	assign serve  = (busy_q == 4'd0) && (cnt1 != '0);
	assign cnt2   = cnt1 - CW'(serve);

	// empty queue: the head is this tick's own arrival
	assign fwd    = (count_q == '0);
	assign hd_arr = fwd ? tick_q : rd_arr;
	assign hd_svc = fwd ? svc_s1 : rd_svc;

	assign wait_c   = serve ? (tick_q - hd_arr) : 32'd0;
	assign busy_new = serve ? hd_svc : busy_q;
	assign busy_dec = (busy_new != 4'd0) ? (busy_new - 4'd1) : 4'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			busy_q  <= '0;
			tick_q  <= '0;
		end else if (calc_go) begin
			if (serve) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
			end
			if (join_c) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
			end
			count_q <= cnt2;
			busy_q  <= busy_dec;
			tick_q  <= tick_q + 32'd1;
		end
	end

	bq_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.AW         (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (calc_go && join_c),
		.wr_addr(tail_q),
		.wr_arr (tick_q),
		.wr_svc (svc_s1),
		.rd_en  (in_acc),
		.rd_addr(head_q),
		.rd_arr (rd_arr),
		.rd_svc (rd_svc)
	);

	assign upd.en         = calc_go;
	assign upd.joined     = join_c;
	assign upd.rejected   = rej_c;
	assign upd.served     = serve;
	assign upd.len        = 48'(cnt2);
	assign upd.wait_ticks = wait_c;

	bq_stats u_stats (
		.clk              (clk),
		.arst_n           (arst_n),
		.upd              (upd),
		.total_joined     (total_joined),
		.total_served     (total_served),
		.total_turned_away(total_turned_away),
		.sum_queue_length (sum_queue_length),
		.sum_wait         (sum_wait)
	);

	// result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (calc_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (calc_go) begin
			joined_q    <= join_c;
			rejected_q  <= rej_c;
			began_q     <= serve;
			wait_q      <= wait_c;
			qlen_q      <= 5'(cnt2);
			busy_left_q <= busy_dec;
		end
	end

	assign out_valid     = out_valid_q;
	assign joined        = joined_q;
	assign turned_away   = rejected_q;
	assign began_service = began_q;
	assign wait_of_begun = wait_q;
	assign queue_length  = qlen_q;
	assign busy_left     = busy_left_q;

endmodule
`default_nettype wire
